// File: hw/rtl/sha256_pkg.sv
// sha-256 hasher package: controller states, round constants and hash functions
package sha256_pkg;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP
    } st_t;

    // compression sequencer
    localparam int STEP_W = 8;
    localparam logic [STEP_W-1:0] LAST_STEP = 8'd130;
    localparam logic [STEP_W-1:0] LAST_WRITE_STEP = 8'd128;
    localparam logic [STEP_W-1:0] LAST_ROUND_STEP = 8'd129;
    localparam logic [STEP_W-1:0] FIRST_ROUND_STEP = 8'd3;

    // padding
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [3:0] LEN_BYTES = 4'd8;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        k = 32'h0;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        round_k = k;
    endfunction

endpackage

// File: hw/rtl/sha_byte_if.sv
// message byte channel: valid/ready handshake with byte payload
interface sha_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       has_byte;
    logic       message_end;

    modport source (output valid, output byte_value, output has_byte, output message_end,
                    input ready);
    modport sink (input valid, input byte_value, input has_byte, input message_end,
                  output ready);
endinterface

// File: hw/rtl/sha_digest_if.sv
// digest word channel: valid/ready handshake with digest word payload
interface sha_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    modport source (output valid, output digest_word, output word_index, output final_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input final_word,
                  output ready);
endinterface

// File: hw/rtl/sha256_message_hasher_core.sv
// sha-256 message hasher top level: byte packing, padding, compression and digest output
//
//  channel | dir | payload                                  | item
//  --------+-----+------------------------------------------+------------------------------
//  msg     | in  | byte_value[7:0], has_byte, message_end   | one message byte or end mark
//  digest  | out | digest_word[31:0], word_index[2:0],      | one digest word, eight per
//          |     | final_word                               | message
//
// items are taken while idle; msg.ready drops while a block is compressed or padding runs
// the compression sequencer runs a 64-byte block as fill, rounds and final add; each round
//   has an even and an odd step, set by the two read ports of the 16-word schedule memory
// message end adds padding bytes (the tail of the last block, and at times a whole
//   spilled block) and one or two compressions
// the digest sits in an output register, so the next message streams in while it drains;
//   only the final add of the next message waits for the register to empty
// rst_n is asynchronous; after reset the block is idle with the initial hash value loaded
module sha256_message_hasher_core (
    input  logic                clk,
    input  logic                rst_n,
    sha_byte_if.sink            msg,
    sha_digest_if.source        digest
);

    // controller
    sha256_pkg::st_t state_reg, state_next;

    // message position and length
    logic [5:0]  pos_reg;
    logic [23:0] partial_reg;
    logic [63:0] cnt_reg;

    // padding sequence
    logic        pad_active_reg;
    logic        pad_first_reg;
    logic [3:0]  len_cnt_reg;

    // compression sequencer
    logic [sha256_pkg::STEP_W-1:0] step_reg;
    logic [31:0] hash_reg [8];
    logic [31:0] vars_reg [8];
    logic [31:0] p_reg;
    logic [31:0] w_reg;

    // output register
    logic        out_busy_reg;
    logic [2:0]  out_idx_reg;
    logic [31:0] dig_reg [8];

    // schedule memory: message block, then the rolling schedule
    logic [31:0] sched_mem [16];
    logic [31:0] rd0_reg, rd1_reg;
    logic [3:0]  ra0, ra1;
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;

    // absorb path
    logic        ready_int;
    logic        absorb_en;
    logic [7:0]  absorb_byte;
    logic [7:0]  len_byte;
    logic [2:0]  len_sel;

    // sequencer decode
    logic [6:0]  r_issue;
    logic [6:0]  r_prev;
    logic        finishing;
    logic        final_go;
    logic        step_odd;
    logic        w_step;
    logic        round_step;
    logic [31:0] w_val;
    logic [31:0] t1, t2;
    logic [31:0] hash_sum [8];
    logic        out_take;

    assign finishing = pad_active_reg && (len_cnt_reg == sha256_pkg::LEN_BYTES);
    assign final_go  = (state_reg == sha256_pkg::ST_COMP) && (step_reg == sha256_pkg::LAST_STEP)
                       && !(finishing && out_busy_reg);
    assign step_odd  = step_reg[0];
    assign r_issue   = step_reg[7:1];
    assign r_prev    = step_reg[7:1] - 7'd1;
    assign w_step    = !step_odd && (step_reg >= 8'd2) && (step_reg <= sha256_pkg::LAST_WRITE_STEP);
    assign round_step = step_odd && (step_reg >= sha256_pkg::FIRST_ROUND_STEP)
                        && (step_reg <= sha256_pkg::LAST_ROUND_STEP);
    assign out_take  = digest.valid && digest.ready;

    // length bytes go out most significant first
    assign len_sel  = 3'd7 - len_cnt_reg[2:0];
    assign len_byte = cnt_reg[{len_sel, 3'b000} +: 8];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (msg.valid)
                begin
                    if (msg.has_byte && (pos_reg == sha256_pkg::LAST_POS))
                        state_next = sha256_pkg::ST_COMP;
                    else if (msg.message_end)
                        state_next = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_PAD:
            begin
                if (pos_reg == sha256_pkg::LAST_POS)
                    state_next = sha256_pkg::ST_COMP;
            end
            sha256_pkg::ST_COMP:
            begin
                if (final_go)
                begin
                    if (finishing || !pad_active_reg)
                        state_next = sha256_pkg::ST_IDLE;
                    else
                        state_next = sha256_pkg::ST_PAD;
                end
            end
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    // controller outputs: handshake and byte source
    always_comb
    begin
        ready_int   = 1'b0;
        absorb_en   = 1'b0;
        absorb_byte = 8'h00;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                ready_int   = 1'b1;
                absorb_en   = msg.valid && msg.has_byte;
                absorb_byte = msg.byte_value;
            end
            sha256_pkg::ST_PAD:
            begin
                absorb_en = 1'b1;
                if (pad_first_reg)
                    absorb_byte = sha256_pkg::PAD_BYTE;
                else if ((len_cnt_reg == 4'd0) && (pos_reg != sha256_pkg::LEN_POS))
                    absorb_byte = 8'h00;
                else
                    absorb_byte = len_byte;
            end
            sha256_pkg::ST_COMP:
            begin
                ready_int = 1'b0;
            end
            default: ready_int = 1'b0;
        endcase
    end

    assign msg.ready = ready_int;

    // schedule reads: even steps w[r-2], w[r-15] (w[r] for r < 16), odd steps w[r-7], w[r-16]
    always_comb
    begin
        if (!step_odd)
        begin
            ra0 = (r_issue[6:4] == 3'd0) ? r_issue[3:0] : r_issue[3:0] - 4'd2;
            ra1 = r_issue[3:0] + 4'd1;
        end
        else
        begin
            ra0 = r_issue[3:0] + 4'd9;
            ra1 = r_issue[3:0];
        end
    end

    // new schedule word from the two partial sums
    assign w_val = (r_prev[6:4] == 3'd0) ? p_reg : p_reg + rd0_reg + rd1_reg;

    // memory write: compression writes back the schedule, otherwise packed message words
    always_comb
    begin
        if (state_reg == sha256_pkg::ST_COMP)
        begin
            mem_we    = w_step && (r_prev[6:4] != 3'd0);
            mem_waddr = r_prev[3:0];
            mem_wdata = w_val;
        end
        else
        begin
            mem_we    = absorb_en && (pos_reg[1:0] == 2'd3);
            mem_waddr = pos_reg[5:2];
            mem_wdata = {partial_reg, absorb_byte};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            sched_mem[mem_waddr] <= mem_wdata;
        rd0_reg <= sched_mem[ra0];
        rd1_reg <= sched_mem[ra1];
    end

    // round function
    assign t1 = vars_reg[7] + sha256_pkg::bsig1(vars_reg[4])
                + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
                + sha256_pkg::round_k(r_prev[5:0]) + w_reg;
    assign t2 = sha256_pkg::bsig0(vars_reg[0])
                + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                   ^ (vars_reg[1] & vars_reg[2]));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            hash_sum[i] = hash_reg[i] + vars_reg[i];
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (absorb_en)
            partial_reg <= {partial_reg[15:0], absorb_byte};

        if (state_reg == sha256_pkg::ST_COMP)
        begin
            if (step_odd)
                p_reg <= (r_issue[6:4] == 3'd0) ? rd0_reg
                         : sha256_pkg::ssig1(rd0_reg) + sha256_pkg::ssig0(rd1_reg);
            if (w_step)
                w_reg <= w_val;
            if (step_reg == '0)
            begin
                for (int i = 0; i < 8; i++)
                    vars_reg[i] <= hash_reg[i];
            end
            else if (round_step)
            begin
                vars_reg[7] <= vars_reg[6];
                vars_reg[6] <= vars_reg[5];
                vars_reg[5] <= vars_reg[4];
                vars_reg[4] <= vars_reg[3] + t1;
                vars_reg[3] <= vars_reg[2];
                vars_reg[2] <= vars_reg[1];
                vars_reg[1] <= vars_reg[0];
                vars_reg[0] <= t1 + t2;
            end
        end

        if (final_go && finishing)
        begin
            for (int i = 0; i < 8; i++)
                dig_reg[i] <= hash_sum[i];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sha256_pkg::ST_IDLE;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            pad_active_reg <= 1'b0;
            pad_first_reg  <= 1'b0;
            len_cnt_reg    <= '0;
            step_reg       <= '0;
            out_busy_reg   <= 1'b0;
            out_idx_reg    <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= sha256_pkg::INIT_H[i];
        end
        else
        begin
            state_reg <= state_next;

            if (absorb_en)
                pos_reg <= pos_reg + 6'd1;

            // item accepted while idle
            if ((state_reg == sha256_pkg::ST_IDLE) && msg.valid)
            begin
                if (msg.has_byte)
                    cnt_reg <= cnt_reg + 64'd8;
                if (msg.message_end)
                begin
                    pad_active_reg <= 1'b1;
                    pad_first_reg  <= 1'b1;
                    len_cnt_reg    <= '0;
                end
            end

            // padding: marker byte, zero fill, then eight length bytes
            if (state_reg == sha256_pkg::ST_PAD)
            begin
                if (pad_first_reg)
                    pad_first_reg <= 1'b0;
                else if ((len_cnt_reg != 4'd0) || (pos_reg == sha256_pkg::LEN_POS))
                    len_cnt_reg <= len_cnt_reg + 4'd1;
            end

            // sequencer holds on the last step until the output register is free
            if (state_reg != sha256_pkg::ST_COMP)
                step_reg <= '0;
            else if (step_reg != sha256_pkg::LAST_STEP)
                step_reg <= step_reg + 8'd1;

            if (final_go)
            begin
                if (finishing)
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= sha256_pkg::INIT_H[i];
                    pad_active_reg <= 1'b0;
                    cnt_reg        <= '0;
                end
                else
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_sum[i];
                end
            end

            // output register drain
            if (final_go && finishing)
            begin
                out_busy_reg <= 1'b1;
                out_idx_reg  <= '0;
            end
            else if (out_take)
            begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (out_idx_reg == 3'd7)
                    out_busy_reg <= 1'b0;
            end
        end
    end

    assign digest.valid       = out_busy_reg;
    assign digest.digest_word = dig_reg[out_idx_reg];
    assign digest.word_index  = out_idx_reg;
    assign digest.final_word  = (out_idx_reg == 3'd7);

endmodule

// File: hw/rtl/sha256_chk.sv
// port checker for the sha-256 hasher, bound to the top level
module sha256_chk (
    input  logic            clk,
    input  logic            rst_n,
    sha_byte_if.sink        msg,
    sha_digest_if.source    digest
);

    // digest words leave in order, without gaps inside one digest
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && !digest.final_word)
        |=> (digest.valid && (digest.word_index == $past(digest.word_index) + 3'd1)))
        else $error("digest word order broken");

    // final flag marks the eighth word only
    a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> (digest.final_word == (digest.word_index == 3'd7)))
        else $error("final_word does not match word_index");

    // a digest always starts at word zero
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && !$past(digest.valid)) |-> (digest.word_index == 3'd0))
        else $error("digest does not start at word zero");

    // a stalled digest word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && !digest.ready)
        |=> (digest.valid && $stable(digest.digest_word) && $stable(digest.word_index)))
        else $error("stalled digest word changed");

    // input ready is always driven out of reset
    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(msg.ready))
        else $error("msg ready unknown");

endmodule

bind sha256_message_hasher_core sha256_chk u_sha256_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .msg    (msg),
    .digest (digest)
);
